/* rtl/atb_pkg.sv */
// Types and constants shared by the ATA task-file command builder.
package atb_pkg;

    localparam int SEQ_DEPTH = 10;

    // floor(2^34 / 63); the quotient taken from it is short by at most one
    localparam logic [28:0] RECIP_63   = 29'd272696336;
    localparam int          RECIP_SHIFT = 34;
    localparam logic [6:0]  SECT_PER_TRACK = 7'd63;

    localparam logic [7:0] DEVSEL_CHS   = 8'hA0;
    localparam logic [7:0] DEVSEL_LBA   = 8'hE0;
    localparam logic [7:0] OP_READ      = 8'h20;
    localparam logic [7:0] OP_READ_EXT  = 8'h24;
    localparam logic [7:0] OP_WRITE     = 8'h30;
    localparam logic [7:0] OP_WRITE_EXT = 8'h34;

    localparam logic [3:0] SEQ_LEN_EXT = 4'd10;
    localparam logic [3:0] SEQ_LEN_STD = 4'd6;

    typedef enum logic [3:0] {
        REG_DEVSEL     = 4'd0,
        REG_COUNT_HIGH = 4'd1,
        REG_LBA3       = 4'd2,
        REG_LBA4       = 4'd3,
        REG_LBA5       = 4'd4,
        REG_COUNT_LOW  = 4'd5,
        REG_LBA0       = 4'd6,
        REG_LBA1       = 4'd7,
        REG_LBA2       = 4'd8,
        REG_COMMAND    = 4'd9
    } t_reg_code;

    typedef struct packed {
        logic        drive_select;
        logic        is_write;
        logic [47:0] block_address;
        logic [7:0]  sector_count;
    } t_req;

    typedef struct packed {
        t_reg_code  reg_code;
        logic [7:0] reg_data;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [1:0] lba_capable;
    } t_cfg;

endpackage

/* rtl/atb_stream_if.sv */
// Valid/ready channel carrying one payload of a chosen type.
interface atb_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ata_taskfile_command_builder_top.sv */
// ATA task-file command builder: request in, ordered task-file register writes out.
//
// i_req carries one sector access request (drive, read/write, 48-bit block
// address, sector count). o_res carries the task-file writes it expands into,
// one per cycle while o_res is ready: ten writes for LBA48, six for LBA28 or
// CHS, the command write flagged by last. i_cfg writes the two-bit LBA-capable
// mask (one bit per drive); it is always ready and should only be written while
// no request is in flight.
// Pipeline: input register, quotient-by-63 multiply, correction and sequence
// build, then a ten-entry write queue that drives o_res straight from flops.
// The first write of a request passes the stage 1, stage 2 and write queue
// registers; the next request's first write follows the previous command write
// with no gap, so requests are bounded by o_res taking at most one write per cycle.
// Up to two further requests are held in the front stages while writes drain.
// When o_res stalls, the queue holds and the front stages fill, then i_req
// drops ready. Synchronous active-low reset empties all stages and clears the
// LBA-capable mask.
module ata_taskfile_command_builder_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    atb_stream_if.sink    i_req,
    atb_stream_if.sink    i_cfg,
    atb_stream_if.source  o_res
);
    import atb_pkg::*;

    // stage 1: request register
    logic        r_s1_v;
    t_req        r_s1_req;
    // stage 2: request plus estimated track number
    logic        r_s2_v;
    t_req        r_s2_req;
    logic [22:0] r_s2_q0;
    // write queue
    t_res        r_ent [SEQ_DEPTH];
    logic [3:0]  r_cnt;
    logic [1:0]  r_lba_cap;

    logic [56:0] w_prod;
    logic [28:0] w_q63;
    logic [27:0] w_diff;
    logic [6:0]  w_rem0;
    logic        w_fix;
    logic [5:0]  w_rem;
    logic [22:0] w_track;
    logic [7:0]  w_sect;
    logic [3:0]  w_head;
    logic [15:0] w_cyl;
    logic        w_ext;
    logic        w_lba;
    logic [7:0]  w_devsel;
    logic [7:0]  w_cmd;
    logic [7:0]  w_b0, w_b1, w_b2;
    t_res        n_ent [SEQ_DEPTH];
    logic [3:0]  n_cnt;

    logic        w_out_take;
    logic        w_load;
    logic        w_s2_free;
    logic        w_s1_free;

    // ---- flow control
    assign w_out_take  = o_res.valid && o_res.ready;
    assign w_load      = r_s2_v && ((r_cnt == 4'd0) || ((r_cnt == 4'd1) && w_out_take));
    assign w_s2_free   = !r_s2_v || w_load;
    assign w_s1_free   = !r_s1_v || w_s2_free;
    assign i_req.ready = w_s1_free;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid = (r_cnt != 4'd0);
    assign o_res.data  = r_ent[0];

    // ---- stage 1: track estimate by reciprocal multiply
    assign w_prod = r_s1_req.block_address[27:0] * RECIP_63;

    // ---- stage 2: remainder correction and sequence build
    assign w_q63   = {r_s2_q0, 6'd0} - {6'd0, r_s2_q0};
    assign w_diff  = r_s2_req.block_address[27:0] - w_q63[27:0];
    assign w_rem0  = w_diff[6:0];
    assign w_fix   = (w_rem0 >= SECT_PER_TRACK);
    assign w_rem   = w_fix ? 6'(w_rem0 - SECT_PER_TRACK) : w_rem0[5:0];
    assign w_track = r_s2_q0 + {22'd0, w_fix};
    assign w_sect  = {2'd0, w_rem} + 8'd1;
    assign w_head  = w_track[3:0];
    assign w_cyl   = w_track[19:4];

    assign w_ext = |r_s2_req.block_address[47:28];
    assign w_lba = r_lba_cap[r_s2_req.drive_select];

    always_comb begin
        if (w_ext || w_lba) begin
            w_b0 = r_s2_req.block_address[7:0];
            w_b1 = r_s2_req.block_address[15:8];
            w_b2 = r_s2_req.block_address[23:16];
        end else begin
            w_b0 = w_sect;
            w_b1 = w_cyl[7:0];
            w_b2 = w_cyl[15:8];
        end

        if (w_ext) begin
            w_devsel = DEVSEL_LBA | {3'd0, r_s2_req.drive_select, 4'd0};
            w_cmd    = r_s2_req.is_write ? OP_WRITE_EXT : OP_READ_EXT;
        end else if (w_lba) begin
            w_devsel = DEVSEL_LBA | {3'd0, r_s2_req.drive_select,
                                     r_s2_req.block_address[27:24]};
            w_cmd    = r_s2_req.is_write ? OP_WRITE : OP_READ;
        end else begin
            w_devsel = DEVSEL_CHS | {3'd0, r_s2_req.drive_select, w_head};
            w_cmd    = r_s2_req.is_write ? OP_WRITE : OP_READ;
        end

        for (int i = 0; i < SEQ_DEPTH; i++) begin
            n_ent[i] = '{reg_code: REG_DEVSEL, reg_data: 8'd0, last: 1'b0};
        end

        n_ent[0] = '{reg_code: REG_DEVSEL, reg_data: w_devsel, last: 1'b0};
        if (w_ext) begin
            n_ent[1] = '{reg_code: REG_COUNT_HIGH, reg_data: 8'd0, last: 1'b0};
            n_ent[2] = '{reg_code: REG_LBA3,
                         reg_data: r_s2_req.block_address[31:24], last: 1'b0};
            n_ent[3] = '{reg_code: REG_LBA4,
                         reg_data: r_s2_req.block_address[39:32], last: 1'b0};
            n_ent[4] = '{reg_code: REG_LBA5,
                         reg_data: r_s2_req.block_address[47:40], last: 1'b0};
            n_ent[5] = '{reg_code: REG_COUNT_LOW,
                         reg_data: r_s2_req.sector_count, last: 1'b0};
            n_ent[6] = '{reg_code: REG_LBA0, reg_data: w_b0, last: 1'b0};
            n_ent[7] = '{reg_code: REG_LBA1, reg_data: w_b1, last: 1'b0};
            n_ent[8] = '{reg_code: REG_LBA2, reg_data: w_b2, last: 1'b0};
            n_ent[9] = '{reg_code: REG_COMMAND, reg_data: w_cmd, last: 1'b1};
            n_cnt    = SEQ_LEN_EXT;
        end else begin
            n_ent[1] = '{reg_code: REG_COUNT_LOW,
                         reg_data: r_s2_req.sector_count, last: 1'b0};
            n_ent[2] = '{reg_code: REG_LBA0, reg_data: w_b0, last: 1'b0};
            n_ent[3] = '{reg_code: REG_LBA1, reg_data: w_b1, last: 1'b0};
            n_ent[4] = '{reg_code: REG_LBA2, reg_data: w_b2, last: 1'b0};
            n_ent[5] = '{reg_code: REG_COMMAND, reg_data: w_cmd, last: 1'b1};
            n_cnt    = SEQ_LEN_STD;
        end
    end

    // ---- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_cnt     <= 4'd0;
            r_lba_cap <= 2'd0;
        end else begin
            if (i_cfg.valid) begin
                r_lba_cap <= i_cfg.data.lba_capable;
            end
            if (w_s1_free) begin
                r_s1_v <= i_req.valid;
            end
            if (w_s2_free) begin
                r_s2_v <= r_s1_v;
            end
            if (w_load) begin
                r_cnt <= n_cnt;
            end else if (w_out_take) begin
                r_cnt <= r_cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_req.valid) begin
            r_s1_req <= i_req.data;
        end
        if (w_s2_free && r_s1_v) begin
            r_s2_req <= r_s1_req;
            r_s2_q0  <= w_prod[RECIP_SHIFT +: 23];
        end
        if (w_load) begin
            r_ent <= n_ent;
        end else if (w_out_take) begin
            // queue head moves up one write per write taken
            for (int i = 0; i < SEQ_DEPTH - 1; i++) begin
                r_ent[i] <= r_ent[i + 1];
            end
        end
    end

    // ---- checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SEQ_LEN_EXT)
        else $error("write queue count out of range");

    a_last_is_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.last |-> o_res.data.reg_code == REG_COMMAND)
        else $error("sequence ends on a write other than the command");

    a_seq_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_take && !o_res.data.last |=> o_res.valid)
        else $error("write sequence broken before the command write");

    a_seq_starts_devsel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_take && o_res.data.last |=>
            !o_res.valid || o_res.data.reg_code == REG_DEVSEL)
        else $error("new sequence does not start with device select");

endmodule
